// ----- design/ookd_pkg.sv -----
// Shared types and constants for the OOK pulse-width frame decoder.
package ookd_pkg;

    // Field widths fixed by the pulse and frame formats
    localparam int PULSE_LEN_W = 20;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int BIT_COUNT_W = 7;
    localparam int WORD_W      = 32;

    // Long low is five unit lengths; bit count saturates at its field maximum
    localparam int LONG_FACTOR   = 5;
    localparam int BIT_COUNT_MAX = 127;

    // Configuration register indexes
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_UNIT_TIME       = 3'd0;
    localparam t_cfg_idx CFG_UNIT_TOLERANCE  = 3'd1;
    localparam t_cfg_idx CFG_START_TIME      = 3'd2;
    localparam t_cfg_idx CFG_START_TOLERANCE = 3'd3;
    localparam t_cfg_idx CFG_STOP_TIME       = 3'd4;

    // Register values after reset
    localparam logic [CFG_W-1:0] UNIT_TIME_RST       = 16'd250;
    localparam logic [CFG_W-1:0] UNIT_TOLERANCE_RST  = 16'd60;
    localparam logic [CFG_W-1:0] START_TIME_RST      = 16'd2600;
    localparam logic [CFG_W-1:0] START_TOLERANCE_RST = 16'd300;
    localparam logic [CFG_W-1:0] STOP_TIME_RST       = 16'd5000;

    // Length class of one pulse
    typedef struct packed {
        logic is_unit;
        logic is_long;
        logic is_start;
        logic is_stop;
    } t_pulse_class;

    // One decoded frame
    typedef struct packed {
        logic                   frame_status;
        logic [BIT_COUNT_W-1:0] bit_count;
        logic [WORD_W-1:0]      message_word;
    } t_frame_result;

    // Control from the pulse FSM to the frame walker
    typedef struct packed {
        logic start;
        logic odd;
        logic take;
    } t_walk_ctl;

    // Status from the frame walker
    typedef struct packed {
        logic          busy;
        logic          done;
        t_frame_result result;
    } t_walk_status;

endpackage

// ----- design/ookd_ifs.sv -----
// Valid/ready channel interfaces for pulses, frames and configuration writes.
interface ookd_pulse_if;
    logic        valid;
    logic        ready;
    logic [19:0] pulse_length;
    logic        pulse_level;

    modport source (output valid, pulse_length, pulse_level, input ready);
    modport sink   (input valid, pulse_length, pulse_level, output ready);
endinterface

interface ookd_frame_if;
    logic        valid;
    logic        ready;
    logic        frame_status;
    logic [6:0]  bit_count;
    logic [31:0] message_word;

    modport source (output valid, frame_status, bit_count, message_word, input ready);
    modport sink   (input valid, frame_status, bit_count, message_word, output ready);
endinterface

interface ookd_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- design/ookd_pulse_class.sv -----
// Pulse length classifier: unit, long low, start low and stop tests.
module ookd_pulse_class (
    input  logic [ookd_pkg::PULSE_LEN_W-1:0] i_pulse_length,
    input  logic [ookd_pkg::CFG_W-1:0]       i_unit_time,
    input  logic [ookd_pkg::CFG_W-1:0]       i_unit_tolerance,
    input  logic [ookd_pkg::CFG_W-1:0]       i_start_time,
    input  logic [ookd_pkg::CFG_W-1:0]       i_start_tolerance,
    input  logic [ookd_pkg::CFG_W-1:0]       i_stop_time,
    output ookd_pkg::t_pulse_class           o_class
);
    import ookd_pkg::*;

    // |len - nominal| <= tol; nominal stays below 2^20
    function automatic logic near_len(
        input logic [PULSE_LEN_W-1:0] len,
        input logic [PULSE_LEN_W-1:0] nominal,
        input logic [CFG_W-1:0]       tol
    );
        logic [PULSE_LEN_W-1:0] diff;
        diff = (len >= nominal) ? (len - nominal) : (nominal - len);
        return diff <= PULSE_LEN_W'(tol);
    endfunction

    logic [PULSE_LEN_W-1:0] long_nominal;

    // Five units by constant multiply (fits in 19 bits)
    assign long_nominal = PULSE_LEN_W'(i_unit_time) * PULSE_LEN_W'(LONG_FACTOR);

    always_comb begin
        o_class.is_unit  = near_len(i_pulse_length, PULSE_LEN_W'(i_unit_time),
                                    i_unit_tolerance);
        o_class.is_long  = near_len(i_pulse_length, long_nominal, i_unit_tolerance);
        o_class.is_start = near_len(i_pulse_length, PULSE_LEN_W'(i_start_time),
                                    i_start_tolerance);
        o_class.is_stop  = i_pulse_length > PULSE_LEN_W'(i_stop_time);
    end

endmodule

// ----- design/ookd_pair_mem.sv -----
// Half-bit store: one row per half-bit pair, two lanes, registered read.
module ookd_pair_mem #(
    parameter int ROWS  = 64,
    parameter int ROW_W = 6
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [ROW_W-1:0] i_wr_row,
    input  logic             i_wr_lane,
    input  logic             i_wr_bit,
    input  logic             i_rd_en,
    input  logic [ROW_W-1:0] i_rd_row,
    output logic [1:0]       o_rd_data
);
    logic [1:0] r_mem [ROWS];

    // Lane 0 holds the first half-bit of a pair, lane 1 the second
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_row][i_wr_lane] <= i_wr_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_row];
        end
    end

endmodule

// ----- design/ookd_frame_walk.sv -----
// Frame-end walker: reads stored pairs, decodes bits and builds the result.
module ookd_frame_walk #(
    parameter int MESSAGE_BITS = 32,
    parameter int PAIR_W       = 7,
    parameter int ROW_W        = 6
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  ookd_pkg::t_walk_ctl     i_ctl,
    input  logic [PAIR_W-1:0]       i_pairs,
    output logic                    o_rd_en,
    output logic [ROW_W-1:0]        o_rd_row,
    input  logic [1:0]              i_rd_data,
    output ookd_pkg::t_walk_status  o_status
);
    import ookd_pkg::*;

    localparam logic [1:0] WK_IDLE = 2'd0;
    localparam logic [1:0] WK_RUN  = 2'd1;
    localparam logic [1:0] WK_HOLD = 2'd2;

    // Only the MSB set: where the first decoded bit lands
    localparam logic [MESSAGE_BITS-1:0] PTR_INIT = ~({MESSAGE_BITS{1'b1}} >> 1);

    logic [1:0]              r_state, n_state;
    logic [PAIR_W-1:0]       r_pairs;
    logic [PAIR_W-1:0]       r_row;
    logic                    r_pend;
    logic                    r_bad;
    logic [MESSAGE_BITS-1:0] r_ptr;
    logic [MESSAGE_BITS-1:0] r_word;
    logic                    issue;
    logic                    finish;

    // One row read per cycle until all pairs are out or a bad pair shows up
    assign issue    = (r_state == WK_RUN) && !r_bad && (r_row != r_pairs);
    assign finish   = (r_state == WK_RUN) && !r_pend && (r_bad || (r_row == r_pairs));
    assign o_rd_en  = issue;
    assign o_rd_row = ROW_W'(r_row);

    always_comb begin
        n_state = r_state;
        case (r_state)
            WK_IDLE: begin
                if (i_ctl.start) begin
                    n_state = WK_RUN;
                end
            end
            WK_RUN: begin
                if (finish) begin
                    n_state = WK_HOLD;
                end
            end
            WK_HOLD: begin
                if (i_ctl.take) begin
                    n_state = WK_IDLE;
                end
            end
            default: n_state = WK_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= WK_IDLE;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= issue;
        end
    end

    // Walk datapath; read data arrives in the cycle after the issue
    always_ff @(posedge i_clk) begin
        if (r_state == WK_IDLE && i_ctl.start) begin
            r_pairs <= i_pairs;
            r_row   <= '0;
            r_bad   <= i_ctl.odd;
            r_ptr   <= PTR_INIT;
            r_word  <= '0;
        end else begin
            if (issue) begin
                r_row <= r_row + 1'b1;
            end
            if (r_pend && !r_bad) begin
                if (i_rd_data[0] == i_rd_data[1]) begin
                    r_bad <= 1'b1;
                end else begin
                    // pair 10 gives a one, 01 a zero; bits past the word are dropped
                    if (i_rd_data[0]) begin
                        r_word <= r_word | r_ptr;
                    end
                    r_ptr <= r_ptr >> 1;
                end
            end
        end
    end

    always_comb begin
        o_status.busy = (r_state != WK_IDLE);
        o_status.done = (r_state == WK_HOLD);
        o_status.result.frame_status = r_bad;
        if (r_bad) begin
            o_status.result.bit_count    = '0;
            o_status.result.message_word = '0;
        end else begin
            if (int'(r_pairs) > BIT_COUNT_MAX) begin
                o_status.result.bit_count = BIT_COUNT_W'(BIT_COUNT_MAX);
            end else begin
                o_status.result.bit_count = BIT_COUNT_W'(r_pairs);
            end
            o_status.result.message_word = WORD_W'(r_word);
        end
    end

endmodule

// ----- design/ook_pulse_width_frame_decoder.sv -----
// Top level of the OOK pulse-width frame decoder.
// Takes one radio pulse per transfer (length in microseconds and level) and
// tracks a sync high, a start low, then data half-bits: a unit high followed
// by a unit low (half-bit 0) or a five-unit low (half-bit 1). A low longer
// than stop_time ends the frame and one frame transfer follows with status,
// bit count and the first MESSAGE_BITS decoded bits, first bit highest. A
// pulse is taken whenever the walker is idle. A pulse that ends a frame
// starts a walk of the half-bit memory at one pair per cycle; pulse input
// is held off while the walk runs and while the previous frame still waits
// at the output. The store needs no clearing after reset: each frame reads
// only entries it wrote itself. Configuration writes are taken in any cycle.
module ook_pulse_width_frame_decoder #(
    parameter int HALF_BIT_DEPTH = 128,
    parameter int MESSAGE_BITS   = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ookd_pulse_if.sink   i_pulse,
    ookd_cfg_if.sink     i_cfg,
    ookd_frame_if.source o_frame
);
    import ookd_pkg::*;

    localparam int CNT_W  = $clog2(HALF_BIT_DEPTH + 1);
    localparam int PAIR_W = CNT_W - 1;
    localparam int ROWS   = (HALF_BIT_DEPTH + 1) / 2;
    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;

    // Receive phases
    localparam logic [1:0] PH_SYNC  = 2'd0;
    localparam logic [1:0] PH_START = 2'd1;
    localparam logic [1:0] PH_HIGH  = 2'd2;
    localparam logic [1:0] PH_LOW   = 2'd3;

    logic [CFG_W-1:0] r_unit_time;
    logic [CFG_W-1:0] r_unit_tolerance;
    logic [CFG_W-1:0] r_start_time;
    logic [CFG_W-1:0] r_start_tolerance;
    logic [CFG_W-1:0] r_stop_time;

    logic [1:0]       r_phase, n_phase;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_out_valid;
    t_frame_result    r_out;

    t_pulse_class     pc;
    t_walk_ctl        walk_ctl;
    t_walk_status     walk_st;
    logic             pulse_xfer;
    logic             cfg_xfer;
    logic             out_load;
    logic             mem_wr_en;
    logic             mem_rd_en;
    logic [ROW_W-1:0] mem_rd_row;
    logic [1:0]       mem_rd_data;

    // Pulses wait while the walker owns the memory
    assign i_pulse.ready = !walk_st.busy;
    assign i_cfg.ready   = 1'b1;
    assign pulse_xfer    = i_pulse.valid && i_pulse.ready;
    assign cfg_xfer      = i_cfg.valid && i_cfg.ready;

    ookd_pulse_class u_class (
        .i_pulse_length    (i_pulse.pulse_length),
        .i_unit_time       (r_unit_time),
        .i_unit_tolerance  (r_unit_tolerance),
        .i_start_time      (r_start_time),
        .i_start_tolerance (r_start_tolerance),
        .i_stop_time       (r_stop_time),
        .o_class           (pc)
    );

    // Frame result moves to the output register when it is free
    assign out_load = walk_st.done && (!r_out_valid || o_frame.ready);

    // Phase machine and half-bit push
    always_comb begin
        n_phase        = r_phase;
        n_count        = r_count;
        mem_wr_en      = 1'b0;
        walk_ctl.start = 1'b0;
        walk_ctl.odd   = r_count[0];
        walk_ctl.take  = out_load;
        if (pulse_xfer) begin
            case (r_phase)
                PH_SYNC: begin
                    if (pc.is_unit && i_pulse.pulse_level) begin
                        n_phase = PH_START;
                    end
                end
                PH_START: begin
                    if (!i_pulse.pulse_level && pc.is_start) begin
                        n_count = '0;
                        n_phase = PH_HIGH;
                    end else begin
                        n_phase = PH_SYNC;
                    end
                end
                PH_HIGH: begin
                    if (pc.is_unit && i_pulse.pulse_level) begin
                        n_phase = PH_LOW;
                    end else begin
                        n_count = '0;
                        n_phase = PH_SYNC;
                    end
                end
                PH_LOW: begin
                    if (!i_pulse.pulse_level && (pc.is_long || pc.is_unit)) begin
                        if (r_count < CNT_W'(HALF_BIT_DEPTH)) begin
                            mem_wr_en = 1'b1;
                            n_count   = r_count + 1'b1;
                            n_phase   = PH_HIGH;
                        end else begin
                            n_count = '0;
                            n_phase = PH_SYNC;
                        end
                    end else begin
                        // stop hands the frame to the walker; anything else drops it
                        walk_ctl.start = !i_pulse.pulse_level && pc.is_stop;
                        n_count        = '0;
                        n_phase        = PH_SYNC;
                    end
                end
                default: n_phase = PH_SYNC;
            endcase
        end
    end

    ookd_pair_mem #(
        .ROWS  (ROWS),
        .ROW_W (ROW_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_row  (ROW_W'(r_count >> 1)),
        .i_wr_lane (r_count[0]),
        .i_wr_bit  (pc.is_long),
        .i_rd_en   (mem_rd_en),
        .i_rd_row  (mem_rd_row),
        .o_rd_data (mem_rd_data)
    );

    ookd_frame_walk #(
        .MESSAGE_BITS (MESSAGE_BITS),
        .PAIR_W       (PAIR_W),
        .ROW_W        (ROW_W)
    ) u_walk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (walk_ctl),
        .i_pairs   (PAIR_W'(r_count >> 1)),
        .o_rd_en   (mem_rd_en),
        .o_rd_row  (mem_rd_row),
        .i_rd_data (mem_rd_data),
        .o_status  (walk_st)
    );

    // Control state and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase           <= PH_SYNC;
            r_count           <= '0;
            r_out_valid       <= 1'b0;
            r_unit_time       <= UNIT_TIME_RST;
            r_unit_tolerance  <= UNIT_TOLERANCE_RST;
            r_start_time      <= START_TIME_RST;
            r_start_tolerance <= START_TOLERANCE_RST;
            r_stop_time       <= STOP_TIME_RST;
        end else begin
            r_phase <= n_phase;
            r_count <= n_count;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_frame.ready) begin
                r_out_valid <= 1'b0;
            end
            if (cfg_xfer) begin
                case (i_cfg.index)
                    CFG_UNIT_TIME:       r_unit_time       <= i_cfg.data;
                    CFG_UNIT_TOLERANCE:  r_unit_tolerance  <= i_cfg.data;
                    CFG_START_TIME:      r_start_time      <= i_cfg.data;
                    CFG_START_TOLERANCE: r_start_tolerance <= i_cfg.data;
                    CFG_STOP_TIME:       r_stop_time       <= i_cfg.data;
                    default: ;
                endcase
            end
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= walk_st.result;
        end
    end

    assign o_frame.valid        = r_out_valid;
    assign o_frame.frame_status = r_out.frame_status;
    assign o_frame.bit_count    = r_out.bit_count;
    assign o_frame.message_word = r_out.message_word;

    // Checks
    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(HALF_BIT_DEPTH))
        else $error("half-bit count beyond store depth");

    a_no_write_during_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_wr_en |-> !walk_st.busy)
        else $error("store written while walker reads it");

    a_walk_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        walk_ctl.start |=> walk_st.busy)
        else $error("frame end did not start the walker");

    a_load_from_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(walk_st.done))
        else $error("frame output without a finished walk");

endmodule
